@@ design/tgi_pkg.sv @@
// Package: types and constants shared by the trilinear grid interpolator.
package tgi_pkg;

  localparam int AXIS_MAX_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PTS_W           = 5;
  localparam int FRAC_BITS       = 16;

  typedef enum logic [1:0] {
    CMD_WR_POINT = 2'd0,
    CMD_WR_TABLE = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_PTS_ONE   = 2'd0,
    CFG_PTS_TWO   = 2'd1,
    CFG_PTS_THREE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         axis_select;
    logic [3:0]         point_index;
    logic [11:0]        table_index;
    logic signed [31:0] write_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         outside_mask;
    logic               degenerate_segment;
  } out_item_t;

endpackage

@@ design/trilinear_grid_interpolator.sv @@
// Trilinear interpolator over a rectilinear 3-D grid of Q16.16 samples.
// A breakpoint or table write goes through the write state. A query walks each
// axis one breakpoint at a time through that axis's breakpoint RAM, fetches
// the bracketing pair and runs a restoring division; it then reads eight
// corners from the sample table and does seven blends in one shared
// multiply-add unit. The block takes no new request until the result has
// been handed off, which waits on out_stall.
module trilinear_grid_interpolator #(
  parameter int AXIS_MAX    = tgi_pkg::AXIS_MAX_DEF,
  parameter int VALUE_WIDTH = tgi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tgi_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tgi_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data
);
  import tgi_pkg::*;

  localparam int AW  = $clog2(AXIS_MAX);
  localparam int TD  = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int TW  = $clog2(TD);
  localparam int RB  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CW  = AW + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRCH  = 10'b0000000010,
    S_SRCHW = 10'b0000000100,
    S_PT1   = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_DIVW  = 10'b0000100000,
    S_CRN   = 10'b0001000000,
    S_BLEND = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WR    = 10'b1000000000
  } state_t;

  state_t state;
  assign cfg_ready = 1'b1;

  // Configuration registers
  logic [4:0] pts [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      pts[0] <= 5'd16; pts[1] <= 5'd16; pts[2] <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PTS_ONE:   pts[0] <= cfg_data;
        CFG_PTS_TWO:   pts[1] <= cfg_data;
        CFG_PTS_THREE: pts[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [CW-1:0] used(input logic [4:0] r);
    if (r < 5'd2) return CW'(2);
    if (32'(r) > AXIS_MAX) return CW'(AXIS_MAX);
    return CW'(r);
  endfunction

  in_item_t req;
  logic [1:0] ax;
  logic [CW-1:0] idx;
  logic [CW-1:0] nused;
  logic [AW-1:0] seg [3];
  logic signed [31:0] p0, pn, ps;
  logic [16:0] frac [3];
  logic [2:0] outm, degm;
  logic signed [31:0] crn [8];
  logic [3:0] cc;
  logic [2:0] bc;
  logic signed [31:0] v;
  logic signed [32:0] numr, denr;
  logic pend;

  // Axis point RAMs and sample table
  logic [AW-1:0] pa;
  logic          pwe [3];
  logic signed [31:0] prd [3];
  for (genvar g = 0; g < 3; g++) begin : g_ax
    tgi_ram #(.WIDTH(32), .DEPTH(AXIS_MAX)) u_pts (
      .clk(clk), .we(pwe[g]), .addr(pa), .wdata(req.write_value), .rdata(prd[g]));
  end
  logic          twe;
  logic [TW-1:0] ta;
  logic signed [31:0] trd;
  tgi_ram #(.WIDTH(32), .DEPTH(TD)) u_tab (
    .clk(clk), .we(twe), .addr(ta), .wdata(req.write_value), .rdata(trd));

  logic signed [31:0] prd_ax;
  assign prd_ax = prd[ax];
  assign v = (ax == 2'd0) ? req.query_x : (ax == 2'd1) ? req.query_y : req.query_z;
  assign nused = used(pts[ax]);

  // Corner coordinates for the table read
  logic [AW-1:0] ca, cb, ce;
  always_comb begin
    for (int g = 0; g < 3; g++) pwe[g] = (state == S_WR) && req.cmd == CMD_WR_POINT
                                       && 32'(req.axis_select) == g
                                       && 32'(req.point_index) < AXIS_MAX;
    twe = (state == S_WR) && req.cmd == CMD_WR_TABLE && 32'(req.table_index) < TD;
    pa = (state == S_WR) ? AW'(req.point_index) : idx[AW-1:0];
    ca = seg[0] + AW'(cc[0]);
    cb = seg[1] + AW'(cc[1]);
    ce = seg[2] + AW'(cc[2]);
    ta = (state == S_WR) ? TW'(req.table_index)
       : TW'((TW'(ca) * TW'(AXIS_MAX) + TW'(cb)) * TW'(AXIS_MAX) + TW'(ce));
  end

  // Divider, started once numerator and denominator are registered
  logic dstart;
  logic dbusy;
  logic [16:0] dq;
  logic [32:0] dnum, dden;
  assign dnum = numr[32] ? 33'(-numr) : 33'(numr);
  assign dden = denr[32] ? 33'(-denr) : 33'(denr);
  assign dstart = (state == S_DIVW) && pend;
  tgi_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
                 .busy(dbusy), .quot(dq));

  // Shared blend unit: a*(1-f) + b*f + half, floor shift
  logic signed [31:0] ba, bb;
  logic [16:0] bf;
  logic signed [32:0] bdiff;
  logic signed [50:0] bprod;
  logic signed [66:0] bsum;
  logic signed [31:0] bres;
  always_comb begin
    case (bc)
      3'd0: begin ba = crn[0]; bb = crn[1]; bf = frac[0]; end
      3'd1: begin ba = crn[2]; bb = crn[3]; bf = frac[0]; end
      3'd2: begin ba = crn[4]; bb = crn[5]; bf = frac[0]; end
      3'd3: begin ba = crn[6]; bb = crn[7]; bf = frac[0]; end
      3'd4: begin ba = crn[0]; bb = crn[2]; bf = frac[1]; end
      3'd5: begin ba = crn[4]; bb = crn[6]; bf = frac[1]; end
      default: begin ba = crn[0]; bb = crn[4]; bf = frac[2]; end
    endcase
    bdiff = 33'(bb) - 33'(ba);
    bprod = $signed({1'b0, bf}) * bdiff;
    bsum = (67'(ba) <<< 16) + 67'(bprod) + 67'sd32768;
    bres = 32'(bsum >>> 16);
  end

  logic signed [34:0] rfull;
  assign rfull = 35'(bsum >>> 16);
  logic signed [31:0] hi, lo, sat;
  assign hi = 32'((64'sd1 <<< (RB - 1)) - 1);
  assign lo = -hi - 32'sd1;
  assign sat = (rfull > 35'(hi)) ? hi : (rfull < 35'(lo)) ? lo : bres;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          req <= in_data;
          ax <= 2'd0; idx <= '0; pend <= 1'b0;
          outm <= '0; degm <= '0;
          case (cmd_t'(in_data.cmd))
            CMD_QUERY: state <= S_SRCH;
            CMD_WR_POINT, CMD_WR_TABLE: state <= S_WR;
            default: state <= S_IDLE;
          endcase
        end
        S_WR: state <= S_IDLE;
        // Issue read of idx; data arrives next cycle
        S_SRCH: state <= S_SRCHW;
        S_SRCHW: begin
          if (idx == '0) begin
            p0 <= prd_ax; seg[ax] <= '0;
          end else if (idx + CW'(1) < nused) begin
            if (prd_ax <= v) seg[ax] <= idx[AW-1:0];
          end else begin
            pn <= prd_ax;
          end
          if (idx + CW'(1) < nused) begin
            idx <= idx + CW'(1); state <= S_SRCH;
          end else begin
            idx <= CW'(seg[ax]); state <= S_PT1; pend <= 1'b0;
          end
        end
        // Fetch p[s] then p[s+1]
        S_PT1: begin
          if (!pend) begin
            pend <= 1'b1;
            outm[ax] <= (v < p0) || (v > pn);
          end else if (idx == CW'(seg[ax])) begin
            idx <= idx + CW'(1);
          end else begin
            state <= S_DIV;
          end
          if (pend && idx == CW'(seg[ax])) ps <= prd_ax;
        end
        S_DIV: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (!dbusy && !pend) begin
            if (denr == 0 || numr == 0 || (numr[32] != denr[32])) frac[ax] <= '0;
            else frac[ax] <= dq;
            degm[ax] <= (denr == 0);
            if (ax == 2'd2) begin
              cc <= '0; state <= S_CRN;
            end else begin
              ax <= ax + 2'd1; idx <= '0; state <= S_SRCH;
            end
          end
          pend <= 1'b0;
        end
        // Read eight corners, one per cycle, from the registered-read sample table
        S_CRN: begin
          if (cc != 4'd0) crn[cc[2:0] - 3'd1] <= trd;
          if (cc == 4'd8) begin
            bc <= '0; state <= S_BLEND;
          end
          cc <= cc + 4'd1;
        end
        S_BLEND: begin
          case (bc)
            3'd0: crn[0] <= bres;
            3'd1: crn[2] <= bres;
            3'd2: crn[4] <= bres;
            3'd3: crn[6] <= bres;
            3'd4: crn[0] <= bres;
            3'd5: crn[4] <= bres;
            default: begin
              out_data.result_value <= sat;
              out_data.outside_mask <= outm;
              out_data.degenerate_segment <= |degm;
              state <= S_OUT;
            end
          endcase
          bc <= bc + 3'd1;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Numerator and denominator for the divider, registered at S_DIV
  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      numr <= 33'(v) - 33'(ps);
      denr <= 33'(prd_ax) - 33'(ps);
    end
  end

endmodule

@@ design/tgi_ram.sv @@
// Generic single-port RAM with registered read.
module tgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/tgi_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient saturated to 1.0.
module tgi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output logic        busy,
  output logic [16:0] quot
);

  // (num<<16)/den over 17 quotient bits; num >= 2*den saturates up front,
  // otherwise the integer part is 0 or 1 and 16 fraction bits follow.
  logic [4:0]  cnt;
  logic [33:0] r;
  logic [32:0] dv;
  logic [16:0] q;
  logic        ovf;
  logic        ge;
  logic [33:0] rdiff;

  assign busy  = (cnt != 5'd0);
  assign ge    = (r >= {1'b0, dv});
  assign rdiff = r - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 5'd0;
    end else if (start) begin
      cnt <= 5'd17;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
    end
  end

  // Compare, subtract and shift one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      r   <= {1'b0, num};
      dv  <= den;
      q   <= '0;
      ovf <= ({1'b0, num} >= {den, 1'b0});
    end else if (busy) begin
      q <= {q[15:0], ge};
      r <= ge ? {rdiff[32:0], 1'b0} : {r[32:0], 1'b0};
    end
  end

  assign quot = (ovf || q > 17'd65536) ? 17'd65536 : q;

endmodule
